>>> sv/ffpa_pkg.sv
// ----------------------------------------------------------------------------
// ffpa_pkg
// shared types, codes and sizes of the first-fit partition allocator
// ----------------------------------------------------------------------------
package ffpa_pkg;

    localparam int MAX_PARTITIONS = 16;
    localparam int SIZE_BITS      = 16;
    localparam int SLOT_BITS      = (MAX_PARTITIONS > 1) ? $clog2(MAX_PARTITIONS) : 1;
    localparam int PIU_BITS       = 5;
    localparam int QUEUE_DEPTH    = 2;
    localparam int QPTR_BITS      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS      = $clog2(QUEUE_DEPTH + 1);

    // command codes on the input channel
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_ALLOC = 1'b1;

    typedef enum logic {
        OP_LOAD  = 1'b0,
        OP_ALLOC = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        OUTCOME_RUN    = 2'd0,
        OUTCOME_WAIT   = 2'd1,
        OUTCOME_LOADED = 2'd2
    } outcome_t;

    // classified transaction handed from front to back
    typedef struct packed {
        op_t                  op;
        logic                 load_ok;
        logic [3:0]           slot;
        logic [SIZE_BITS-1:0] amount;
    } item_t;

endpackage

>>> sv/ffpa_front.sv
// ----------------------------------------------------------------------------
// ffpa_front
// accepts input transactions, classifies them and queues them for the back end
// ----------------------------------------------------------------------------
module ffpa_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 command,
    input  logic [3:0]           slot_index,
    input  logic [15:0]          amount_kb,
    output logic                 q_valid,
    output ffpa_pkg::item_t      q_item,
    input  logic                 q_pop
);
    import ffpa_pkg::*;

    item_t                slots_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] wr_ptr_reg;
    logic [QPTR_BITS-1:0] wr_ptr_next;
    logic [QPTR_BITS-1:0] rd_ptr_reg;
    logic [QPTR_BITS-1:0] rd_ptr_next;
    logic [QCNT_BITS-1:0] count_reg;
    logic [QCNT_BITS-1:0] count_next;
    logic                 push;
    item_t                classified;

    // decode and range check
    always_comb
    begin
        classified.op      = (command == CMD_ALLOC) ? OP_ALLOC : OP_LOAD;
        classified.load_ok = (32'(slot_index) < MAX_PARTITIONS);
        classified.slot    = slot_index;
        classified.amount  = SIZE_BITS'(amount_kb);
    end

    assign in_stall = (count_reg == QCNT_BITS'(QUEUE_DEPTH));
    assign push     = in_valid && !in_stall;
    assign q_valid  = (count_reg != '0);
    assign q_item   = slots_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (32'(wr_ptr_reg) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (q_pop)
        begin
            rd_ptr_next = (32'(rd_ptr_reg) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, q_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_ptr_reg] <= classified;
        end
    end

endmodule

>>> sv/ffpa_back.sv
// ----------------------------------------------------------------------------
// ffpa_back
// free-space table, first-fit search and result register
// ----------------------------------------------------------------------------
module ffpa_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic [4:0]           cfg_wr_data,
    input  logic                 q_valid,
    input  ffpa_pkg::item_t      q_item,
    output logic                 q_pop,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [1:0]           outcome,
    output logic [3:0]           granted_slot,
    output logic [15:0]          space_left_kb
);
    import ffpa_pkg::*;

    logic [SIZE_BITS-1:0] free_reg [MAX_PARTITIONS];
    logic [PIU_BITS-1:0]  piu_reg;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    outcome_t             outcome_reg;
    outcome_t             outcome_next;
    logic [SLOT_BITS-1:0] granted_reg;
    logic [SLOT_BITS-1:0] granted_next;
    logic [SIZE_BITS-1:0] left_reg;
    logic [SIZE_BITS-1:0] left_next;

    logic [MAX_PARTITIONS-1:0] fit;
    logic                      hit;
    logic [SLOT_BITS-1:0]      hit_idx;
    logic [SIZE_BITS-1:0]      hit_left;
    logic [SLOT_BITS-1:0]      load_idx;
    logic                      do_load;
    logic                      do_alloc;

    // result register frees up when empty or being taken
    assign q_pop = q_valid && (!out_valid_reg || !out_stall);

    // parallel compare, masked to the searched partitions
    always_comb
    begin
        for (int j = 0; j < MAX_PARTITIONS; j++)
        begin
            fit[j] = (32'(piu_reg) > j) && (q_item.amount <= free_reg[j]);
        end
    end

    // lowest-numbered fitting partition wins
    always_comb
    begin
        hit     = 1'b0;
        hit_idx = '0;
        for (int j = MAX_PARTITIONS - 1; j >= 0; j--)
        begin
            if (fit[j])
            begin
                hit     = 1'b1;
                hit_idx = SLOT_BITS'(j);
            end
        end
    end

    assign hit_left = free_reg[hit_idx] - q_item.amount;
    assign load_idx = SLOT_BITS'(q_item.slot);
    assign do_load  = q_pop && (q_item.op == OP_LOAD) && q_item.load_ok;
    assign do_alloc = q_pop && (q_item.op == OP_ALLOC) && hit;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        outcome_next   = outcome_reg;
        granted_next   = granted_reg;
        left_next      = left_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (q_pop)
        begin
            out_valid_next = 1'b1;
            case (q_item.op)
                OP_LOAD:
                begin
                    outcome_next = OUTCOME_LOADED;
                    granted_next = '0;
                    left_next    = '0;
                end
                OP_ALLOC:
                begin
                    outcome_next = hit ? OUTCOME_RUN : OUTCOME_WAIT;
                    granted_next = hit ? hit_idx : '0;
                    left_next    = hit ? hit_left : '0;
                end
                default:
                begin
                    outcome_next = OUTCOME_WAIT;
                    granted_next = '0;
                    left_next    = '0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            piu_reg       <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                piu_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        outcome_reg <= outcome_next;
        granted_reg <= granted_next;
        left_reg    <= left_next;
        if (do_load)
        begin
            free_reg[load_idx] <= q_item.amount;
        end
        else if (do_alloc)
        begin
            free_reg[hit_idx] <= hit_left;
        end
    end

    assign out_valid     = out_valid_reg;
    assign outcome       = outcome_reg;
    assign granted_slot  = 4'(granted_reg);
    assign space_left_kb = 16'(left_reg);

endmodule

>>> sv/first_fit_partition_allocator.sv
// ----------------------------------------------------------------------------
// first_fit_partition_allocator
// first-fit allocation over a table of per-partition free space
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake            payload
//   in       input      in_valid / in_stall   command, slot_index, amount_kb
//   out      output     out_valid / out_stall outcome, granted_slot, space_left_kb
//   cfg      input      cfg_wr_en             cfg_wr_data (partitions_in_use)
//
// one transaction per cycle sustained while out_stall is low; an accepted
// transaction goes into the queue at the accept edge, then into the result register
// once that is free; the throughput is set by the parallel compare and table update
// reset clears queue pointers, result valid and partitions_in_use; the free
// space table is not reset and must be loaded before an entry is searched
// a stalled output keeps its result; the two-entry queue absorbs input until
// full, then in_stall rises
//
module first_fit_partition_allocator (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [4:0]  cfg_wr_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        command,
    input  logic [3:0]  slot_index,
    input  logic [15:0] amount_kb,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  outcome,
    output logic [3:0]  granted_slot,
    output logic [15:0] space_left_kb
);
    import ffpa_pkg::*;

    // front to back queue interface
    logic  q_valid;
    logic  q_pop;
    item_t q_item;

    // accept and classify, buffer in a short queue
    ffpa_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .command    (command),
        .slot_index (slot_index),
        .amount_kb  (amount_kb),
        .q_valid    (q_valid),
        .q_item     (q_item),
        .q_pop      (q_pop)
    );

    // table, first-fit search and registered result
    ffpa_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .q_valid       (q_valid),
        .q_item        (q_item),
        .q_pop         (q_pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .outcome       (outcome),
        .granted_slot  (granted_slot),
        .space_left_kb (space_left_kb)
    );

endmodule

>>> dv/first_fit_partition_allocator_chk.sv
// ----------------------------------------------------------------------------
// first_fit_partition_allocator_chk
// watches the channels, predicts every result and compares it
// ----------------------------------------------------------------------------
module first_fit_partition_allocator_chk (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [4:0]  cfg_wr_data,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic        command,
    input  logic [3:0]  slot_index,
    input  logic [15:0] amount_kb,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [1:0]  outcome,
    input  logic [3:0]  granted_slot,
    input  logic [15:0] space_left_kb,
    output int          err_count,
    output int          pending
);

    timeunit 1ns;
    timeprecision 1ps;

    import ffpa_pkg::*;

    typedef struct packed {
        outcome_t             outcome;
        logic [3:0]           slot;
        logic [SIZE_BITS-1:0] left;
    } grant_t;

    logic [SIZE_BITS-1:0] free_kb [MAX_PARTITIONS];
    logic [PIU_BITS-1:0]  partitions;
    grant_t               grant_q [$];

    initial begin
        err_count = 0;
        pending   = 0;
    end

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        err_count++;
    endtask

    // applies a load, or a first-fit search over the partitions in use; updates the table
    function automatic grant_t first_fit_grant(input logic cmd, input logic [3:0] slot,
                                               input logic [15:0] amount);
        grant_t               g;
        int                   lim;
        logic [SIZE_BITS-1:0] job;
        job       = amount[SIZE_BITS-1:0];
        g.outcome = OUTCOME_WAIT;
        g.slot    = '0;
        g.left    = '0;
        if (op_t'(cmd) == OP_LOAD) begin
            if (int'(slot) < MAX_PARTITIONS)
                free_kb[slot] = job;
            g.outcome = OUTCOME_LOADED;
        end
        else begin
            lim = (int'(partitions) > MAX_PARTITIONS) ? MAX_PARTITIONS : int'(partitions);
            for (int j = 0; j < lim; j++) begin
                if (job <= free_kb[j]) begin
                    free_kb[j] = free_kb[j] - job;
                    g.outcome  = OUTCOME_RUN;
                    g.slot     = 4'(j);
                    g.left     = free_kb[j];
                    break;
                end
            end
        end
        return g;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        grant_t want;
        if (!rst_n) begin
            grant_q.delete();
            partitions = '0;
            pending    = 0;
        end
        else begin
            if (cfg_wr_en)
                partitions = cfg_wr_data;
            if (out_valid && !out_stall) begin
                if (grant_q.size() == 0) begin
                    report_mismatch($sformatf("result with nothing expected: outcome %0d",
                                              outcome));
                end
                else begin
                    want = grant_q.pop_front();
                    if (outcome !== want.outcome)
                        report_mismatch($sformatf("outcome %0d, expected %0d",
                                                  outcome, want.outcome));
                    if (granted_slot !== want.slot)
                        report_mismatch($sformatf("granted_slot %0d, expected %0d",
                                                  granted_slot, want.slot));
                    if (space_left_kb !== want.left)
                        report_mismatch($sformatf("space_left_kb %0d, expected %0d",
                                                  space_left_kb, want.left));
                end
            end
            if (in_valid && !in_stall)
                grant_q.push_back(first_fit_grant(command, slot_index, amount_kb));
            pending = grant_q.size();
        end
    end

endmodule

>>> dv/first_fit_partition_allocator_tb.sv
// ----------------------------------------------------------------------------
// first_fit_partition_allocator_tb
// drives load and allocate commands through the allocator under random
// sender bursts and receiver stalls; a side checker predicts each result
// ----------------------------------------------------------------------------
module first_fit_partition_allocator_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import ffpa_pkg::*;

    localparam int PHASE_ITEMS = 250;
    localparam int PHASES      = 7;
    // longest accepted-nothing stretch: heavy stall runs, config pauses
    localparam int IDLE_LIMIT  = 4000;

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [4:0]  cfg_wr_data;
    logic        in_valid;
    logic        in_stall;
    logic        command;
    logic [3:0]  slot_index;
    logic [15:0] amount_kb;
    logic        out_valid;
    logic        out_stall;
    logic [1:0]  outcome;
    logic [3:0]  granted_slot;
    logic [15:0] space_left_kb;

    int err_count;
    int pending;
    int burst_left;
    int idle_cycles;

    first_fit_partition_allocator u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .command       (command),
        .slot_index    (slot_index),
        .amount_kb     (amount_kb),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .outcome       (outcome),
        .granted_slot  (granted_slot),
        .space_left_kb (space_left_kb)
    );

    first_fit_partition_allocator_chk u_chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .command       (command),
        .slot_index    (slot_index),
        .amount_kb     (amount_kb),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .outcome       (outcome),
        .granted_slot  (granted_slot),
        .space_left_kb (space_left_kb),
        .err_count     (err_count),
        .pending       (pending)
    );

    // 100 MHz clock
    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // receiver stall: a mode is held for a random stretch, then another is picked
    // mode 0 never stalls, mode 4 alternates, the rest stall at a fixed rate
    initial begin
        int mode;
        int hold;
        int pct;
        bit flip;
        out_stall = 1'b0;
        mode      = 0;
        hold      = 0;
        flip      = 1'b0;
        forever begin
            @(negedge clk);
            if (hold == 0) begin
                mode = $urandom_range(4);
                hold = $urandom_range(400, 40);
            end
            hold--;
            case (mode)
                0:       pct = 0;
                1:       pct = 20;
                2:       pct = 50;
                3:       pct = 85;
                default: pct = -1;
            endcase
            flip = ~flip;
            if (pct < 0)
                out_stall <= flip;
            else
                out_stall <= ($urandom_range(99) < pct);
        end
    end

    // watchdog: counts edges with no transaction on any channel
    always @(posedge clk) begin
        if (!rst_n || cfg_wr_en || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // one command transaction; the sender may idle between bursts of random length
    task automatic push_command(input op_t op, input logic [3:0] slot,
                                input logic [15:0] amount);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(24, 1);
            // a quarter of the bursts follow the previous one back to back
            gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(6, 1);
            if (gap > 0) begin
                @(negedge clk);
                in_valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        in_valid   <= 1'b1;
        command    <= op;
        slot_index <= slot;
        amount_kb  <= amount;
        // held until the transaction is taken
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    // register write once the pipe has drained
    task automatic set_partitions(input logic [4:0] count);
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= count;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        burst_left = 0;
    endtask

    // random load or allocate; loads lean large so that jobs keep finding room,
    // jobs lean small so that a partition serves several before it runs dry
    task automatic push_random(input int load_pct);
        int          pick;
        logic [15:0] amount;
        pick = $urandom_range(99);
        if ($urandom_range(99) < load_pct) begin
            if (pick < 55)      amount = 16'($urandom_range(65535));
            else if (pick < 85) amount = 16'($urandom_range(65535, 32768));
            else if (pick < 93) amount = 16'($urandom_range(255));
            else if (pick < 97) amount = 16'h0000;
            else                amount = 16'hffff;
            push_command(OP_LOAD, 4'($urandom_range(15)), amount);
        end
        else begin
            if (pick < 40)      amount = 16'($urandom_range(255));
            else if (pick < 65) amount = 16'($urandom_range(4095));
            else if (pick < 85) amount = 16'($urandom_range(65535));
            else if (pick < 95) amount = 16'h0000;
            else                amount = 16'hffff;
            push_command(OP_ALLOC, 4'($urandom_range(15)), amount);
        end
    endtask

    initial begin
        logic [4:0] count;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        in_valid    = 1'b0;
        command     = CMD_LOAD;
        slot_index  = '0;
        amount_kb   = '0;
        burst_left  = 0;
        idle_cycles = 0;
        rst_n       = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // empty search: no partition in use, every job waits and nothing is read
        set_partitions(5'd0);
        push_command(OP_ALLOC, 4'hf, 16'h0000);
        push_command(OP_ALLOC, 4'h0, 16'hffff);

        // fill the whole table before any search can touch it
        push_command(OP_LOAD, 4'd0, 16'h0000);
        push_command(OP_LOAD, 4'd1, 16'hffff);
        push_command(OP_LOAD, 4'd2, 16'h5555);
        push_command(OP_LOAD, 4'd3, 16'haaaa);
        for (int s = 4; s < MAX_PARTITIONS; s++)
            push_command(OP_LOAD, 4'(s), 16'($urandom_range(65535)));

        // zero-size job lands on the empty first partition, a full-size job
        // takes the largest, a small job skips the drained ones
        set_partitions(5'd16);
        push_command(OP_ALLOC, 4'h0, 16'h0000);
        push_command(OP_ALLOC, 4'h0, 16'hffff);
        push_command(OP_ALLOC, 4'h0, 16'h0001);
        push_command(OP_ALLOC, 4'h0, 16'hffff);

        // random phases; register above table size saturates, zero waits all
        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0:       count = 5'd1;
                1:       count = 5'd31;
                2:       count = 5'd16;
                3:       count = 5'd0;
                4:       count = 5'd17;
                default: count = 5'($urandom_range(31));
            endcase
            set_partitions(count);
            for (int i = 0; i < PHASE_ITEMS; i++)
                push_random((p == 3) ? 50 : $urandom_range(45, 15));
        end

        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (err_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
